/* rtl/core/smt_pkg.sv */
// shared constants and types for the stepper microstep tracker
`timescale 1ns / 1ps

package smt_pkg;

	// angle format: unsigned, 9 integer bits plus a configurable fraction
	localparam int ANGLE_INT_BITS      = 9;
	localparam int ANGLE_FRAC_BITS_DEF = 16;

	// step size and level fields
	localparam int STEP_W     = 24;
	localparam int LEVEL_W    = 4;
	localparam int MODE_W     = 3;
	localparam int MAX_LEVELS = 8;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = STEP_W;

	localparam logic [CFG_IDX_W-1:0] CFG_FULL_STEP_SIZE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MICROSTEP_LEVELS = 1'b1;

	localparam logic [STEP_W-1:0]  FULL_STEP_RESET = 24'd117965;
	localparam logic [LEVEL_W-1:0] LEVELS_RESET    = 4'd6;

	// chosen step for one update
	typedef struct packed {
		logic              found;
		logic              dir;
		logic [MODE_W-1:0] mode;
		logic [STEP_W-1:0] size;
	} step_pick_t;

endpackage

/* rtl/core/smt_in_if.sv */
// update channel: carries the target angle of one beat
`timescale 1ns / 1ps

interface smt_in_if #(
	parameter int AW = 25
);
	logic          valid;
	logic          ready;
	logic [AW-1:0] target_angle;

	modport source (output valid, output target_angle, input ready);
	modport sink   (input valid, input target_angle, output ready);
endinterface

/* rtl/core/smt_out_if.sv */
// step channel: carries the step decision and new position of one beat
`timescale 1ns / 1ps

interface smt_out_if #(
	parameter int AW = 25
);
	logic          valid;
	logic          ready;
	logic          step_pulse;
	logic          direction;
	logic [2:0]    mode;
	logic [AW-1:0] position;

	modport source (output valid, output step_pulse, output direction, output mode,
		output position, input ready);
	modport sink   (input valid, input step_pulse, input direction, input mode,
		input position, output ready);
endinterface

/* rtl/core/smt_step_pick.sv */
// shortest angle difference and largest fitting microstep
`timescale 1ns / 1ps

module smt_step_pick import smt_pkg::*; #(
	parameter int FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
	input  logic [ANGLE_INT_BITS+FRAC_BITS-1:0] target,
	input  logic [ANGLE_INT_BITS+FRAC_BITS-1:0] believed,
	input  logic [STEP_W-1:0]                   full_step,
	input  logic [LEVEL_W-1:0]                  levels,
	output step_pick_t                          pick
);

	localparam int AW = ANGLE_INT_BITS + FRAC_BITS;
	localparam int CW = (AW > STEP_W) ? AW : STEP_W;
	localparam logic [AW-1:0] DEG_360 = AW'(360) << FRAC_BITS;
	localparam logic [AW-1:0] DEG_180 = AW'(180) << FRAC_BITS;

	logic [AW-1:0]         target_w;
	logic signed [AW:0]    sdiff;
	logic [AW:0]           mag_full;
	logic [AW-1:0]         mag;
	logic                  neg;
	logic                  wrap;
	logic [AW-1:0]         gap;
	logic                  dir_raw;
	logic [STEP_W-1:0]     size_m [MAX_LEVELS];
	logic [MAX_LEVELS-1:0] fit;

	// fold target into one turn, then shortest way around
	always_comb begin
		target_w = (target >= DEG_360) ? (target - DEG_360) : target;
		sdiff    = signed'({1'b0, target_w}) - signed'({1'b0, believed});
		neg      = sdiff[AW];
		mag_full = neg ? (~sdiff + 1'b1) : sdiff;
		mag      = mag_full[AW-1:0];
		wrap     = (mag > DEG_180);
		gap      = wrap ? (DEG_360 - mag) : mag;
		dir_raw  = ~neg ^ wrap;
	end

	// every level compared in parallel
	always_comb begin
		for (int m = 0; m < MAX_LEVELS; m++) begin
			size_m[m] = full_step >> m;
			fit[m]    = (LEVEL_W'(m) < levels) && (size_m[m] != '0) &&
				(CW'(size_m[m]) <= CW'(gap));
		end
	end

	// lowest fitting level wins
	always_comb begin
		pick = '0;
		for (int m = MAX_LEVELS - 1; m >= 0; m--) begin
			if (fit[m]) begin
				pick.found = 1'b1;
				pick.mode  = MODE_W'(m);
				pick.size  = size_m[m];
			end
		end
		pick.dir = pick.found & dir_raw;
	end

endmodule

/* rtl/core/smt_pos_update.sv */
// believed angle after one step, wrapped into one turn
`timescale 1ns / 1ps

module smt_pos_update import smt_pkg::*; #(
	parameter int FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
	input  logic [ANGLE_INT_BITS+FRAC_BITS-1:0] believed,
	input  step_pick_t                          pick,
	output logic [ANGLE_INT_BITS+FRAC_BITS-1:0] position
);

	localparam int AW = ANGLE_INT_BITS + FRAC_BITS;
	localparam logic [AW+1:0] DEG_360 = (AW+2)'(360) << FRAC_BITS;

	logic [AW+1:0] base;
	logic [AW+1:0] step;
	logic [AW+1:0] moved;
	logic [AW+1:0] wrapped;

	always_comb begin
		base  = {2'b00, believed};
		// size never exceeds half a turn, so it fits the angle width
		step  = (AW+2)'(pick.size);
		moved = pick.dir ? (base + step) : (base - step);
		if (moved[AW+1]) begin
			wrapped = moved + DEG_360;
		end else if (moved >= DEG_360) begin
			wrapped = moved - DEG_360;
		end else begin
			wrapped = moved;
		end
		position = pick.found ? wrapped[AW-1:0] : believed;
	end

endmodule

/* rtl/core/stepper_microstep_tracker_core.sv */
// top level of the stepper microstep tracker
`timescale 1ns / 1ps

// Stepper microstep tracker. Each beat on the target channel brings a wanted
// angle (unsigned, 9 integer bits and FRAC_BITS fraction bits, degrees). The
// block keeps the believed motor angle, takes the shortest signed way to the
// target (going around past 180 degrees when shorter), picks the largest step
// full_step_size >> m, m below microstep_levels, that does not overshoot, and
// returns one beat on the step channel: step_pulse, direction, mode = m and
// the new believed angle wrapped into [0,360). When no size fits, step_pulse,
// direction and mode are 0 and the position is unchanged. Targets at or
// above 360 degrees are folded back by one turn. Rate: one beat per clock
// while the step channel is not stalled. The target is taken into the input
// register, then one pass of difference, level compare and angle update is
// registered into the output register, which holds while the step channel
// stalls. The believed angle is registered with that result and feeds the next
// beat. Write configuration only while idle; register 0 is full_step_size,
// register 1 is microstep_levels.
module stepper_microstep_tracker_core import smt_pkg::*; #(
	parameter int FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	smt_in_if.sink                target,
	smt_out_if.source             step
);

	localparam int AW = ANGLE_INT_BITS + FRAC_BITS;

	// configuration registers
	logic [STEP_W-1:0]  full_step_q;
	logic [LEVEL_W-1:0] levels_q;

	// input stage
	logic          valid_s1;
	logic [AW-1:0] target_s1;

	// tracked angle
	logic [AW-1:0] believed_q;

	// output register
	logic              out_valid_q;
	logic              pulse_q;
	logic              dir_q;
	logic [MODE_W-1:0] mode_q;
	logic [AW-1:0]     pos_q;

	logic          advance;
	logic          take;
	step_pick_t    pick;
	logic [AW-1:0] next_pos;

	// output register frees when empty or its beat is taken
	assign advance      = ~out_valid_q | step.ready;
	assign target.ready = ~valid_s1 | advance;
	assign take         = target.valid & target.ready;

	// config writes; the user must write only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_step_q <= FULL_STEP_RESET;
			levels_q    <= LEVELS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FULL_STEP_SIZE:   full_step_q <= cfg_data[STEP_W-1:0];
				CFG_MICROSTEP_LEVELS: levels_q    <= cfg_data[LEVEL_W-1:0];
				default:              ;
			endcase
		end
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (target.ready) begin
			valid_s1 <= target.valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (take) begin
			target_s1 <= target.target_angle;
		end
	end

	smt_step_pick #(
		.FRAC_BITS (FRAC_BITS)
	) u_pick (
		.target    (target_s1),
		.believed  (believed_q),
		.full_step (full_step_q),
		.levels    (levels_q),
		.pick      (pick)
	);

	smt_pos_update #(
		.FRAC_BITS (FRAC_BITS)
	) u_pos (
		.believed (believed_q),
		.pick     (pick),
		.position (next_pos)
	);

	// believed angle and output valid move together with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			believed_q  <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				believed_q <= next_pos;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			pulse_q <= pick.found;
			dir_q   <= pick.dir;
			mode_q  <= pick.mode;
			pos_q   <= next_pos;
		end
	end

	assign step.valid      = out_valid_q;
	assign step.step_pulse = pulse_q;
	assign step.direction  = dir_q;
	assign step.mode       = mode_q;
	assign step.position   = pos_q;

`ifndef NO_ASSERTIONS
	// a shown position is always the tracked angle
	a_pos_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (pos_q == believed_q))
		else $error("shown position differs from tracked angle");

	// no step means no direction and no mode
	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pulse_q) |-> (!dir_q && (mode_q == '0)))
		else $error("direction or mode set without a step");

	// tracked angle stays inside one turn
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |-> (believed_q < (AW'(360) << FRAC_BITS)))
		else $error("tracked angle out of range");

	// a stalled output freezes the tracked angle
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !step.ready) |=> $stable(believed_q))
		else $error("tracked angle moved while output stalled");
`endif

endmodule

/* bench/tb_top.sv */
// self-checking bench for the stepper microstep tracker: directed table, then random phases
`timescale 1ns / 1ps

module tb_top;
	import smt_pkg::*;

	// angle format at the default fraction width
	localparam int     FRAC    = ANGLE_FRAC_BITS_DEF;
	localparam int     AW      = ANGLE_INT_BITS + FRAC;
	localparam longint DEG_180 = longint'(180) << FRAC;
	localparam longint DEG_360 = longint'(360) << FRAC;
	localparam int     N_PHASES = 10;

	// one step beat as seen on the output channel
	typedef struct packed {
		logic              step;
		logic              dir;
		logic [MODE_W-1:0] mode;
		logic [AW-1:0]     pos;
	} step_beat_t;

	// one row of the directed table: typed rows carry their own expectation
	typedef struct packed {
		logic [AW-1:0] tgt;
		logic          typed;
		step_beat_t    want;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	smt_in_if  #(.AW(AW)) target_if ();
	smt_out_if #(.AW(AW)) step_if ();

	stepper_microstep_tracker_core #(.FRAC_BITS(FRAC)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.target    (target_if),
		.step      (step_if)
	);

	// bench copy of the tracker: believed angle and the two registers
	longint           angle_est;
	logic [STEP_W-1:0]  fs_cfg;
	logic [LEVEL_W-1:0] levels_cfg;

	step_beat_t step_beats_due [$];
	int unsigned mismatches;
	bit          calm;

	// directed rows, all under the reset settings and starting from angle 0
	stim_row_t dir_rows [15] = '{
		// zero difference: nothing fits, no step
		'{25'd0,        1'b1, '{1'b0, 1'b0, 3'd0, 25'd0}},
		// exactly one full step forward, then back
		'{25'd117965,   1'b1, '{1'b1, 1'b1, 3'd0, 25'd117965}},
		'{25'd0,        1'b1, '{1'b1, 1'b0, 3'd0, 25'd0}},
		// just below a full turn: one lsb the other way round, too small to step
		'{25'd23592959, 1'b1, '{1'b0, 1'b0, 3'd0, 25'd0}},
		// exactly half a turn stays in the plain (increasing) direction
		'{25'd11796480, 1'b1, '{1'b1, 1'b1, 3'd0, 25'd117965}},
		'{25'd0,        1'b1, '{1'b1, 1'b0, 3'd0, 25'd0}},
		'{25'd1,        1'b1, '{1'b0, 1'b0, 3'd0, 25'd0}},
		// finest level at the reset count, truncated size
		'{25'd3686,     1'b1, '{1'b1, 1'b1, 3'd5, 25'd3686}},
		'{25'd0,        1'b1, '{1'b1, 1'b0, 3'd5, 25'd0}},
		// a full turn folds back to zero
		'{25'd23592960, 1'b1, '{1'b0, 1'b0, 3'd0, 25'd0}},
		// all ones, well above a turn
		'{25'd33554431, 1'b0, '0},
		'{25'd16777216, 1'b0, '0},
		'{25'd8388607,  1'b0, '0},
		'{25'd23589274, 1'b0, '0},
		'{25'd11796481, 1'b0, '0}
	};

	// works out the beat for one accepted target and moves the bench angle
	function automatic step_beat_t next_step(input logic [AW-1:0] tgt);
		step_beat_t res;
		longint     diff;
		longint     sz;
		bit         up;
		int         tries;
		res  = '0;
		diff = (longint'(tgt) % DEG_360) - angle_est;
		up   = 1'b1;
		if (diff < 0) begin
			up   = 1'b0;
			diff = -diff;
		end
		// shorter to go the other way round
		if (diff > DEG_180) begin
			diff = DEG_360 - diff;
			up   = !up;
		end
		tries = (levels_cfg > MAX_LEVELS) ? MAX_LEVELS : int'(levels_cfg);
		for (int m = 0; m < tries; m++) begin
			sz = fs_cfg >> m;
			if (sz != 0 && sz <= diff) begin
				angle_est = up ? angle_est + sz : angle_est - sz;
				if (angle_est >= DEG_360) angle_est -= DEG_360;
				if (angle_est < 0) angle_est += DEG_360;
				res.step = 1'b1;
				res.dir  = up;
				res.mode = MODE_W'(m);
				res.pos  = AW'(angle_est);
				return res;
			end
		end
		// no level fits: flags stay low, angle unchanged
		res.pos = AW'(angle_est);
		return res;
	endfunction

	// random target, mostly close to the current angle so every level gets picked
	function automatic logic [AW-1:0] pick_target();
		int unsigned sel;
		int unsigned span;
		longint      a;
		sel  = $urandom_range(99);
		span = (fs_cfg >> $urandom_range(0, 8)) * 2 + 4;
		a    = angle_est;
		if (sel >= 70)
			return AW'($urandom_range(0, int'(DEG_360) - 1));
		if (sel >= 65)
			return AW'($urandom_range(int'(DEG_360), (1 << AW) - 1));
		if (sel < 45)
			a = a + longint'($urandom_range(0, 2 * span)) - longint'(span);
		else if (sel < 60)
			// around the half-turn boundary, exact half included
			a = a + DEG_180 + longint'($urandom_range(0, 8)) - 4;
		// otherwise keep the same angle: zero difference
		return AW'(((a % DEG_360) + DEG_360) % DEG_360);
	endfunction

	// idle length: mostly none or short, a few long
	function automatic int unsigned idle_len();
		int unsigned sel;
		sel = $urandom_range(99);
		if (calm || sel < 55)
			return 0;
		if (sel < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// one target beat; on acceptance, record what the step beat must be
	task automatic send_target(input logic [AW-1:0] tgt, input logic typed,
			input step_beat_t want);
		step_beat_t  guess;
		int unsigned pause;
		target_if.valid        <= 1'b1;
		target_if.target_angle <= tgt;
		do @(posedge clk); while (!target_if.ready);
		guess = next_step(tgt);
		step_beats_due.push_back(typed ? want : guess);
		@(negedge clk);
		pause = idle_len();
		if (pause != 0) begin
			target_if.valid <= 1'b0;
			repeat (pause) @(negedge clk);
		end
	endtask

	// hold off the sender until every step beat has come back
	task automatic settle_results();
		target_if.valid <= 1'b0;
		while (step_beats_due.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// write both registers on back-to-back cycles while idle
	task automatic load_settings(input logic [STEP_W-1:0] fs, input logic [LEVEL_W-1:0] lv);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_FULL_STEP_SIZE;
		cfg_data  <= fs;
		@(negedge clk);
		cfg_index <= CFG_MICROSTEP_LEVELS;
		cfg_data  <= CFG_DATA_W'(lv);
		@(negedge clk);
		cfg_we    <= 1'b0;
		fs_cfg     = fs;
		levels_cfg = lv;
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver: random back-pressure on the step channel
	initial begin
		int unsigned stall;
		step_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = idle_len();
			if (stall != 0) begin
				step_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			step_if.ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	end

	// checker: each accepted step beat against the oldest expectation
	always @(posedge clk) begin
		step_beat_t want;
		if (arst_n && step_if.valid && step_if.ready) begin
			if (step_beats_due.size() == 0) begin
				$error("step beat with nothing expected");
				mismatches++;
			end else begin
				want = step_beats_due.pop_front();
				if (step_if.step_pulse !== want.step) begin
					$error("step_pulse: expected %0d, got %0d", want.step, step_if.step_pulse);
					mismatches++;
				end
				if (step_if.direction !== want.dir) begin
					$error("direction: expected %0d, got %0d", want.dir, step_if.direction);
					mismatches++;
				end
				if (step_if.mode !== want.mode) begin
					$error("mode: expected %0d, got %0d", want.mode, step_if.mode);
					mismatches++;
				end
				if (step_if.position !== want.pos) begin
					$error("position: expected %0d, got %0d", want.pos, step_if.position);
					mismatches++;
				end
			end
		end
	end

	// stimulus
	initial begin
		int unsigned        n;
		logic [STEP_W-1:0]  fs;
		logic [LEVEL_W-1:0] lv;
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_index              = '0;
		cfg_data               = '0;
		target_if.valid        = 1'b0;
		target_if.target_angle = '0;
		mismatches             = 0;
		calm                   = 1'b0;
		angle_est              = 0;
		fs_cfg                 = FULL_STEP_RESET;
		levels_cfg             = LEVELS_RESET;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table under the reset settings
		foreach (dir_rows[i])
			send_target(dir_rows[i].tgt, dir_rows[i].typed, dir_rows[i].want);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			n  = 155;
			fs = FULL_STEP_RESET;
			lv = LEVELS_RESET;
			if (ph != 0) begin
				settle_results();
				case (ph)
					1: begin fs = 24'd1; lv = 4'd1; end
					// largest step with all eight levels
					2: begin fs = 24'd11796480; lv = 4'd8; end
					// level count above eight is clamped
					3: begin fs = 24'd11796480; lv = 4'd15; end
					// zero full step: never a step
					4: begin fs = '0; lv = 4'd6; n = 40; end
					// zero levels: never a step
					5: begin fs = FULL_STEP_RESET; lv = '0; n = 40; end
					6: begin fs = 24'd1; lv = 4'd8; end
					7: begin
						fs = STEP_W'($urandom_range(1, 11796480));
						lv = LEVEL_W'($urandom_range(1, 8));
					end
					8: begin
						fs = STEP_W'($urandom_range(1, 4096));
						lv = LEVEL_W'($urandom_range(0, 15));
					end
					default: begin
						fs = STEP_W'($urandom_range(1, 1 << 20));
						lv = 4'd8;
					end
				endcase
				load_settings(fs, lv);
			end
			// every third phase runs without idling on either side
			calm = (ph % 3 == 2);
			for (int k = 0; k < n; k++) begin
				send_target(pick_target(), 1'b0, '0);
				// now and then let the pipeline run dry mid-phase
				if ($urandom_range(99) == 0)
					settle_results();
			end
		end

		settle_results();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/smt_pkg.sv
rtl/core/smt_in_if.sv
rtl/core/smt_out_if.sv
rtl/core/smt_step_pick.sv
rtl/core/smt_pos_update.sv
rtl/core/stepper_microstep_tracker_core.sv
bench/tb_top.sv
